// ----- src/assert_macros.svh -----
// assertion macros used by aes128_block_cipher
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/aes_pkg.sv -----
// aes-128 package: state type, s-box tables, round functions
// no dependencies
`default_nettype none

package aes_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned NUM_RKEYS = 11;

    typedef logic [127:0] block_t;

    typedef enum logic [0:0] {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } cfg_index_t;

    typedef enum logic {
        ACT_ENCRYPT = 1'b0,
        ACT_DECRYPT = 1'b1
    } action_t;

    typedef struct packed {
        logic   vld;
        logic   dec;
    } stage_ctl_t;

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [0:255];
        t = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        sbox = t[x];
    endfunction

    function automatic logic [7:0] rev_sbox(input logic [7:0] x);
        logic [7:0] t [0:255];
        t = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        rev_sbox = t[x];
    endfunction

    // byte i sits at bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(input block_t s, input int i);
        get_byte = s[127 - 8 * i -: 8];
    endfunction

    function automatic block_t enc_round(input block_t s, input block_t rk, input logic last);
        block_t t;
        block_t m;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] = sbox(get_byte(s, r + 4 * ((c + r) % 4)));
            end
        end
        m = t;
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = get_byte(t, 4 * c);
                a1 = get_byte(t, 4 * c + 1);
                a2 = get_byte(t, 4 * c + 2);
                a3 = get_byte(t, 4 * c + 3);
                m[127 - 8 * (4 * c) -: 8]     = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                m[127 - 8 * (4 * c + 1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                m[127 - 8 * (4 * c + 2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                m[127 - 8 * (4 * c + 3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        enc_round = m ^ rk;
    endfunction

    function automatic block_t inv_mix(input block_t s);
        block_t m;
        logic [7:0] a [0:3];
        logic [7:0] x2 [0:3];
        logic [7:0] x4 [0:3];
        logic [7:0] x8 [0:3];
        m = s;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k] = get_byte(s, 4 * c + k);
                x2[k] = xt(a[k]);
                x4[k] = xt(x2[k]);
                x8[k] = xt(x4[k]);
            end
            for (int r = 0; r < 4; r++) begin
                // coefficients 14, 11, 13, 9 rotated by row
                m[127 - 8 * (4 * c + r) -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r]) ^
                    (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ a[(r + 1) % 4]) ^
                    (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ a[(r + 2) % 4]) ^
                    (x8[(r + 3) % 4] ^ a[(r + 3) % 4]);
            end
        end
        inv_mix = m;
    endfunction

    function automatic block_t dec_round(input block_t s, input block_t rk, input logic last);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] =
                    rev_sbox(get_byte(s, r + 4 * ((c - r + 4) % 4)));
            end
        end
        t = t ^ rk;
        dec_round = last ? t : inv_mix(t);
    endfunction

    function automatic block_t next_rkey(input block_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_rkey = {w0, w1, w2, w3};
    endfunction

endpackage

`default_nettype wire

// ----- src/aes_keysched.sv -----
// aes-128 key expansion, one round key per cycle after reset or a key write
// depends on aes_pkg
`default_nettype none

module aes_keysched (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  key_load,
    input  wire aes_pkg::block_t       key,
    output aes_pkg::block_t            rkeys [0:aes_pkg::NUM_RKEYS-1],
    output logic                       busy
);
    import aes_pkg::*;

    block_t     rk_reg [0:NUM_RKEYS-1];
    logic [3:0] idx_reg;
    logic [7:0] rc_reg;
    logic       busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            idx_reg <= 4'd1;
            rc_reg <= 8'h01;
            rk_reg[0] <= '0;
        end else if (key_load) begin
            busy_reg <= 1'b1;
            idx_reg <= 4'd1;
            rc_reg <= 8'h01;
            rk_reg[0] <= key;
        end else if (busy_reg) begin
            rk_reg[idx_reg] <= next_rkey(rk_reg[idx_reg - 4'd1], rc_reg);
            rc_reg <= xt(rc_reg);
            idx_reg <= idx_reg + 4'd1;
            if (idx_reg == 4'(NUM_ROUNDS)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_RKEYS; i++) begin
            rkeys[i] = rk_reg[i];
        end
    end
    assign busy = busy_reg;

endmodule

`default_nettype wire

// ----- src/aes_round_stage.sv -----
// one registered cipher round, encrypt or decrypt chosen per beat
// depends on aes_pkg
`default_nettype none

module aes_round_stage (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  advance,
    input  wire aes_pkg::stage_ctl_t   ctl_in,
    input  wire aes_pkg::block_t       data_in,
    input  wire aes_pkg::block_t       enc_key,
    input  wire aes_pkg::block_t       dec_key,
    input  wire logic                  last,
    output aes_pkg::stage_ctl_t        ctl_out,
    output aes_pkg::block_t            data_out
);
    import aes_pkg::*;

    stage_ctl_t ctl_reg;
    block_t     data_reg;
    block_t     data_next;

    always_comb begin
        data_next = ctl_in.dec ? dec_round(data_in, dec_key, last)
                               : enc_round(data_in, enc_key, last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (advance) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign data_out = data_reg;

endmodule

`default_nettype wire

// ----- src/aes128_block_cipher.sv -----
// aes-128 top level: key registers, key schedule, ten round stages
// depends on aes_pkg, aes_keysched, aes_round_stage, assert_macros.svh
// Fully unrolled pipeline: one beat accepted per cycle while not stalled or busy;
// the result passes one initial key-add register plus ten round registers.
// The whole pipeline advances together and holds when the output is stalled.
// After reset or a key write the key schedule computes the round keys, during
// which no beat is accepted.
`default_nettype none

`include "assert_macros.svh"

module aes128_block_cipher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [63:0] s_block_high,
    input  wire logic [63:0] s_block_low,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_result_high,
    output logic [63:0]      m_result_low
);
    import aes_pkg::*;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        key_load;
    block_t      rkeys [0:NUM_RKEYS-1];
    logic        ks_busy;
    logic        advance;

    stage_ctl_t  ctl [0:NUM_ROUNDS];
    block_t      data [0:NUM_ROUNDS];
    stage_ctl_t  ctl0_reg;
    block_t      data0_reg;

    assign cfg_ready = 1'b1;
    assign key_load = cfg_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LOW:  key_low_reg <= cfg_data;
                default:      key_high_reg <= key_high_reg;
            endcase
        end
    end

    aes_keysched u_keysched (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key_load (key_load),
        .key      ((cfg_index_t'(cfg_index) == CFG_KEY_HIGH)
                   ? {cfg_data, key_low_reg} : {key_high_reg, cfg_data}),
        .rkeys    (rkeys),
        .busy     (ks_busy)
    );

    assign advance = !m_valid || m_ready;
    assign s_ready = advance && !ks_busy && !cfg_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl0_reg <= '0;
        end else if (advance) begin
            ctl0_reg.vld <= s_valid && s_ready;
            ctl0_reg.dec <= s_action;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data0_reg <= {s_block_high, s_block_low}
                         ^ ((s_action == ACT_DECRYPT) ? rkeys[NUM_ROUNDS] : rkeys[0]);
        end
    end

    assign ctl[0] = ctl0_reg;
    assign data[0] = data0_reg;

    for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
        aes_round_stage u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .ctl_in   (ctl[r-1]),
            .data_in  (data[r-1]),
            .enc_key  (rkeys[r]),
            .dec_key  (rkeys[NUM_ROUNDS - r]),
            .last     (r == NUM_ROUNDS),
            .ctl_out  (ctl[r]),
            .data_out (data[r])
        );
    end

    assign m_valid = ctl[NUM_ROUNDS].vld;
    assign m_result_high = data[NUM_ROUNDS][127:64];
    assign m_result_low = data[NUM_ROUNDS][63:0];

    `ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, ks_busy, !(s_valid && s_ready))
    `ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_high))
    `ASSERT_NEXT(a_stage_moves, aclk, aresetn, advance && ctl[NUM_ROUNDS-1].vld, m_valid)

endmodule

`default_nettype wire
